### rtl/sdf_pkg.sv
// ---------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream duplicate filter.
// ---------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    // Width of one list element.
    localparam int VALUE_W = 32;

    // Width of the list tag kept with every table slot.
    localparam int EPOCH_W = 8;

    // Largest tag before the table must be swept again.
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // First tag in use after a sweep; tag zero marks an empty slot.
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_EMIT
    } sdf_state_t;

endpackage : sdf_pkg

`default_nettype wire

### rtl/sdf_mem.sv
// ---------------------------------------------------------------------------
// sdf_mem
// Hash table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 40
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : sdf_mem

`default_nettype wire

### rtl/stream_duplicate_filter.sv
// ---------------------------------------------------------------------------
// stream_duplicate_filter
// Marks repeated values within a list, using an open-addressed hash table.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (value, end_of_list) arrive on in_valid/in_ready. Each beat
//   yields exactly one output beat (value_out, keep, last_out, set_full) on
//   out_valid/out_ready. keep is 1 on the first appearance of a value in
//   the current list, 0 on a repeat. end_of_list closes the list: the beat
//   itself is judged against the set, then the set is emptied.
//   Up to CAPACITY distinct values are recorded per list; a new value that
//   finds the table full is kept and flagged with set_full.
// Probing:
//   Each beat probes P (1..CAPACITY) table slots by linear probing from
//   the hashed slot, one read per cycle through the single read port of
//   the table. The result then passes the emit step into the output
//   register. A new beat is taken only once the last one has left emit.
// Reset and clearing:
//   After reset, and after every 255th list, the block sweeps all
//   CAPACITY table slots and holds in_ready low meanwhile. Lists are
//   otherwise emptied at once by advancing a list tag stored per slot.
// Stall:
//   A finished beat waits in the output register; the next input beat is
//   taken meanwhile and is held in its last step until out_ready frees it.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_duplicate_filter #(
    parameter int CAPACITY = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [sdf_pkg::VALUE_W-1:0]  value,
    input  wire logic                                end_of_list,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [sdf_pkg::VALUE_W-1:0]  value_out,
    output logic                                     keep,
    output logic                                     last_out,
    output logic                                     set_full
);

    import sdf_pkg::*;

    // Slot index width and table word layout.
    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MW     = EPOCH_W + VALUE_W;
    localparam int NCHUNK = (VALUE_W + AW - 1) / AW;
    localparam logic [AW:0]   CAP_W    = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    // State and control registers.
    sdf_state_t        state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [AW-1:0]     clr_idx_reg;
    logic              out_valid_reg;

    // Item under work.
    logic [VALUE_W-1:0] val_reg;
    logic               last_in_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      probes_reg;
    logic               res_keep_reg;
    logic               res_full_reg;

    // Output register payload.
    logic [VALUE_W-1:0] value_out_reg;
    logic               keep_reg;
    logic               last_out_reg;
    logic               set_full_reg;

    // Table port signals.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [MW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [MW-1:0]     mem_rdata;

    // Hash and probe decode.
    logic [VALUE_W-1:0] value_u;
    logic [AW-1:0]      fold;
    logic [AW:0]        fold_wide;
    logic [AW-1:0]      start_idx;
    logic [AW-1:0]      idx_adv;
    logic [EPOCH_W-1:0] rd_tag;
    logic [VALUE_W-1:0] rd_val;
    logic               occupied;
    logic               hit;
    logic               probe_last;
    logic               resolved;
    logic               out_free;
    logic               clr_last;
    logic               accept;
    logic               wrap_epoch;

    sdf_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fold the value into a slot index: xor of AW-bit chunks, then bring it
    // below CAPACITY with one conditional subtract.
    assign value_u = value;

    always_comb
    begin
        fold = '0;
        for (int k = 0; k < NCHUNK; k++)
        begin
            fold = fold ^ AW'(value_u >> (k * AW));
        end
    end

    assign fold_wide = {1'b0, fold};
    assign start_idx = (fold_wide >= CAP_W) ? AW'(fold_wide - CAP_W) : fold;

    // Linear probing wraps at the table end.
    assign idx_adv = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // A slot belongs to the current list only when its tag matches.
    assign rd_tag     = mem_rdata[MW-1 -: EPOCH_W];
    assign rd_val     = mem_rdata[VALUE_W-1:0];
    assign occupied   = (rd_tag == epoch_reg);
    assign hit        = occupied && (rd_val == val_reg);
    assign probe_last = (probes_reg == LAST_IDX);
    assign resolved   = hit || !occupied || probe_last;

    assign out_free   = !out_valid_reg || out_ready;
    assign clr_last   = (clr_idx_reg == LAST_IDX);
    assign accept     = in_valid && in_ready;
    assign wrap_epoch = (epoch_reg == EPOCH_MAX);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (resolved)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (last_in_reg && wrap_epoch) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Table accesses and input handshake per state.
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {epoch_reg, val_reg};
        mem_re    = 1'b0;
        mem_raddr = start_idx;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Stamp every slot with the empty tag.
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                // Read the home slot while taking the beat.
                in_ready  = 1'b1;
                mem_re    = in_valid;
                mem_raddr = start_idx;
            end
            S_PROBE:
            begin
                if (!occupied)
                begin
                    // Record the new value in the free slot.
                    mem_we = 1'b1;
                end
                else if (!hit && !probe_last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_adv;
                end
            end
            S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            epoch_reg     <= EPOCH_FIRST;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_last ? '0 : clr_idx_reg + 1'b1;
            end

            // Advance the list tag when the closing beat leaves.
            if (state_reg == S_EMIT && out_free && last_in_reg)
            begin
                epoch_reg <= wrap_epoch ? EPOCH_FIRST : epoch_reg + 1'b1;
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and output payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg     <= value_u;
            last_in_reg <= end_of_list;
            idx_reg     <= start_idx;
            probes_reg  <= '0;
        end

        if (state_reg == S_PROBE)
        begin
            if (resolved)
            begin
                res_keep_reg <= !hit;
                res_full_reg <= occupied && !hit;
            end
            else
            begin
                idx_reg    <= idx_adv;
                probes_reg <= probes_reg + 1'b1;
            end
        end

        if (state_reg == S_EMIT && out_free)
        begin
            value_out_reg <= val_reg;
            keep_reg      <= res_keep_reg;
            last_out_reg  <= last_in_reg;
            set_full_reg  <= res_full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign keep      = keep_reg;
    assign last_out  = last_out_reg;
    assign set_full  = set_full_reg;

    // Tag zero is reserved for empty slots once the sweep is done.
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |-> epoch_reg != '0)
        else $error("list tag is zero outside the sweep");

    // A value is recorded only into a slot that the probe found empty.
    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> (state_reg == S_PROBE && !occupied))
        else $error("table write outside an empty-slot insert");

    // A full report always comes with a keep mark.
    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_full_reg) |-> res_keep_reg)
        else $error("set_full without keep");

    // A taken beat starts probing on the next cycle.
    a_accept_probe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PROBE)
        else $error("accepted beat did not start probing");

endmodule : stream_duplicate_filter

`default_nettype wire
